@@ design/clfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfp_pkg
// Shared types, constants and helper functions for the Content-Length frame
// parser.
// ----------------------------------------------------------------------------
package clfp_pkg;

  localparam int unsigned PrefixLen = 18;
  localparam int unsigned PmW       = 5;
  localparam logic [31:0] MaxPayloadReset = 32'd1048576;
  localparam logic [31:0] Sat32           = 32'hFFFF_FFFF;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_LENGTH  = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [1:0]  status;
    logic [31:0] frame_size;
  } out_item_t;

  // Request after classification by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] lower;
    logic       chunk_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
  } byte_class_t;

  // Lowercase text of the length line prefix, CR LF "content-length: ".
  function automatic logic [7:0] prefix_char(input logic [PmW-1:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = ChCr;
      5'd1:    c = ChLf;
      5'd2:    c = 8'h63; // c
      5'd3:    c = 8'h6F; // o
      5'd4:    c = 8'h6E; // n
      5'd5:    c = 8'h74; // t
      5'd6:    c = 8'h65; // e
      5'd7:    c = 8'h6E; // n
      5'd8:    c = 8'h74; // t
      5'd9:    c = 8'h2D; // -
      5'd10:   c = 8'h6C; // l
      5'd11:   c = 8'h65; // e
      5'd12:   c = 8'h6E; // n
      5'd13:   c = 8'h67; // g
      5'd14:   c = 8'h74; // t
      5'd15:   c = 8'h68; // h
      5'd16:   c = 8'h3A; // :
      5'd17:   c = 8'h20; // space
      default: c = ChCr;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/clfp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfp_front
// Classifies each incoming byte: case folding, line break and digit flags.
// ----------------------------------------------------------------------------
module clfp_front
  import clfp_pkg::*;
(
  input  wire in_item_t    item,
  output byte_class_t      cls
);

  logic [7:0] b;

  assign b = item.data_byte;

  always_comb begin
    cls.data_byte = b;
    cls.chunk_end = item.chunk_end;
    cls.lower     = (b >= 8'h41 && b <= 8'h5A) ? (b + 8'd32) : b;
    cls.is_cr     = (b == ChCr);
    cls.is_lf     = (b == ChLf);
    cls.is_digit  = (b >= 8'h30 && b <= 8'h39);
    cls.digit     = b[3:0];
  end

endmodule
`default_nettype wire

@@ design/clfp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfp_queue
// Two-entry queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module clfp_queue
  import clfp_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire byte_class_t push_data,
  output logic             full,
  input  wire              pop,
  output logic             pop_valid,
  output byte_class_t      pop_data
);

  byte_class_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ design/clfp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfp_back
// Frame state machine: blank line and length line search, length digits,
// payload countdown, and the registered result stage.
// ----------------------------------------------------------------------------
module clfp_back
  import clfp_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              req_valid,
  input  wire byte_class_t req,
  output logic             req_pop,
  input  wire              cfg_we,
  input  wire [31:0]       cfg_wdata,
  output logic             out_valid,
  input  wire              out_stall,
  output out_item_t        out_item
);

  phase_t          phase_r, phase_nxt;
  logic [1:0]      blank_r, blank_nxt;
  logic [PmW-1:0]  pm_r, pm_nxt;
  logic            found_r, found_nxt;
  logic            digits_r, digits_nxt;
  logic [31:0]     plen_r, plen_nxt;
  logic [31:0]     left_r, left_nxt;
  logic [31:0]     fbytes_r, fbytes_nxt;
  logic [31:0]     max_payload_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            room;
  logic [31:0]     fb_inc;
  logic [31:0]     left_dec;
  logic [35:0]     plen_prod;
  logic            done;
  logic [PmW-1:0]  pm_cur;
  logic            emit;
  out_item_t       res;

  // A new request is taken whenever the result register is free or drains.
  assign room    = !out_valid_r || !out_stall;
  assign req_pop = req_valid && room;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign fb_inc    = (fbytes_r == Sat32) ? fbytes_r : fbytes_r + 32'd1;
  assign left_dec  = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;
  assign plen_prod = {1'b0, plen_r, 3'b000} + {3'b000, plen_r, 1'b0}
                   + {32'd0, req.digit};
  assign done      = (blank_r == 2'd3) && req.is_lf;
  assign pm_cur    = (pm_r < PmW'(PrefixLen)) ? pm_r : '0;

  always_comb begin
    phase_nxt  = phase_r;
    blank_nxt  = blank_r;
    pm_nxt     = pm_r;
    found_nxt  = found_r;
    digits_nxt = digits_r;
    plen_nxt   = plen_r;
    left_nxt   = left_r;
    fbytes_nxt = fbytes_r;
    emit       = 1'b0;
    res        = '0;

    if (req_pop) begin
      fbytes_nxt = fb_inc;
      if (phase_r == PH_PAYLOAD) begin
        res.out_byte   = req.data_byte;
        res.byte_valid = 1'b1;
        emit           = 1'b1;
        left_nxt       = left_dec;
        if (left_dec == 32'd0) begin
          res.frame_end  = 1'b1;
          res.status     = ST_OK;
          res.frame_size = fb_inc;
        end else if (req.chunk_end) begin
          res.status = ST_INCOMPLETE;
        end
      end else begin
        if (req.is_cr) begin
          blank_nxt = (blank_r == 2'd2) ? 2'd3 : 2'd1;
        end else if (req.is_lf && blank_r == 2'd1) begin
          blank_nxt = 2'd2;
        end else begin
          blank_nxt = 2'd0;
        end

        if (digits_r) begin
          if (req.is_digit) begin
            plen_nxt = (plen_prod[35:32] != 4'd0) ? Sat32 : plen_prod[31:0];
          end else begin
            digits_nxt = 1'b0;
          end
        end else if (!found_r) begin
          if (req.lower == prefix_char(pm_cur)) begin
            if (pm_cur == PmW'(PrefixLen - 1)) begin
              found_nxt  = 1'b1;
              digits_nxt = 1'b1;
              plen_nxt   = 32'd0;
              pm_nxt     = '0;
            end else begin
              pm_nxt = pm_cur + PmW'(1);
            end
          end else begin
            pm_nxt = req.is_cr ? PmW'(1) : '0;
          end
        end

        if (done && (!found_nxt || plen_nxt > max_payload_r || plen_nxt == 32'd0)) begin
          emit           = 1'b1;
          res.frame_end  = 1'b1;
          res.frame_size = fb_inc;
          if (!found_nxt) begin
            res.status = ST_NO_LENGTH;
          end else if (plen_nxt > max_payload_r) begin
            res.status = ST_TOO_LONG;
          end else begin
            res.status = ST_OK;
          end
        end else begin
          if (done) begin
            phase_nxt  = PH_PAYLOAD;
            left_nxt   = plen_nxt;
            blank_nxt  = 2'd0;
            pm_nxt     = '0;
            digits_nxt = 1'b0;
          end
          if (req.chunk_end) begin
            emit       = 1'b1;
            res.status = ST_INCOMPLETE;
          end
        end
      end

      // Any frame end starts the next header from scratch.
      if (res.frame_end) begin
        phase_nxt  = PH_HEADER;
        blank_nxt  = 2'd0;
        pm_nxt     = '0;
        found_nxt  = 1'b0;
        digits_nxt = 1'b0;
        plen_nxt   = 32'd0;
        left_nxt   = 32'd0;
        fbytes_nxt = 32'd0;
      end
    end

    if (req_pop) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_item_nxt = (req_pop && emit) ? res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      blank_r       <= 2'd0;
      pm_r          <= '0;
      found_r       <= 1'b0;
      digits_r      <= 1'b0;
      plen_r        <= 32'd0;
      left_r        <= 32'd0;
      fbytes_r      <= 32'd0;
      max_payload_r <= MaxPayloadReset;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      blank_r     <= blank_nxt;
      pm_r        <= pm_nxt;
      found_r     <= found_nxt;
      digits_r    <= digits_nxt;
      plen_r      <= plen_nxt;
      left_r      <= left_nxt;
      fbytes_r    <= fbytes_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

@@ design/content_length_frame_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// content_length_frame_parser
// Splits a byte stream into header-framed messages sized by their
// Content-Length line and passes the payload bytes out.
//
// Input channel (in_valid / in_stall / in_item): one stream byte per request,
// with a flag that marks the last byte of a received buffer.
// Output channel (out_valid / out_stall / out_item): payload bytes, frame end
// marks with the frame size, error and incomplete-buffer reports. Header
// bytes give no output unless they end a dropped header, an empty frame or a buffer.
// Configuration: cfg_we writes cfg_wdata into the payload size limit.
//
// A byte accepted on the input is classified on its way into a two-entry
// queue, handled by the frame state machine, and its result is registered
// in the result register that drives the output. One byte is handled per
// cycle while a byte is queued and no held result is stalled.
// Reset sets the limit to 1048576 bytes and waits for a header. While the
// receiver stalls, the result register holds; the queue takes up to two more
// bytes before in_stall rises.
// ----------------------------------------------------------------------------
module content_length_frame_parser
  import clfp_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire            out_stall,
  output out_item_t      out_item,
  input  wire            cfg_we,
  input  wire [31:0]     cfg_wdata
);

  byte_class_t cls;
  byte_class_t q_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  clfp_front u_front (
    .item (in_item),
    .cls  (cls)
  );

  clfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  clfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (q_valid),
    .req       (q_data),
    .req_pop   (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ design/clfp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfp_checker
// Port-level checks of the frame parser's result channel.
// ----------------------------------------------------------------------------
module clfp_checker
  import clfp_pkg::*;
(
  input wire            clk,
  input wire            rst_n,
  input wire            out_valid,
  input wire            out_stall,
  input wire out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Only a frame end carries a frame size.
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.frame_end |-> out_item.frame_size == 32'd0)
    else $error("frame size outside frame end");

  // A header byte result that does not end a frame is an incomplete report.
  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid && !out_item.frame_end
      |-> out_item.status == ST_INCOMPLETE)
    else $error("header result without incomplete status");

  // A dropped header never carries a payload byte.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_NO_LENGTH || out_item.status == ST_TOO_LONG)
      |-> out_item.frame_end && !out_item.byte_valid)
    else $error("bad dropped header result");

  // The last payload byte of a frame always ends it cleanly.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.byte_valid && out_item.frame_end |-> out_item.status == ST_OK)
    else $error("payload frame end with error status");

endmodule

bind content_length_frame_parser clfp_checker u_clfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
